/* hdl/modular_exponentiation_macros.svh */
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shared property forms for the checker of the modular exponentiation block.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MODEXP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("modular exponentiation check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MODEXP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modular exponentiation check failed");

`endif

/* hdl/modexp_pkg.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, constants and the command and status types shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package modexp_pkg;

   localparam int DATA_WIDTH = 63;
   localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

   localparam logic [CNT_WIDTH-1:0]  CNT_LAST      = CNT_WIDTH'(DATA_WIDTH - 1);
   localparam logic [DATA_WIDTH-1:0] MODULUS_RESET = DATA_WIDTH'(1000000007);
   localparam logic [DATA_WIDTH-1:0] VALUE_ONE     = DATA_WIDTH'(1);

   localparam int REQ_TDATA_WIDTH = ((2 * DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;

   typedef enum logic [1:0] {
      OUT_ACC,
      OUT_ONE,
      OUT_ZERO
   } modexp_out_sel_type;

   typedef struct packed {
      logic               load;         // capture base and exponent, clear the work registers
      logic               reduce_step;  // one bit of reducing the base modulo the modulus
      logic               mul_start;    // load the multiplier with the running value
      logic               mul_sel_base; // multiplicand is the reduced base, else the running value
      logic               mul_step;     // one shift-add step of the modular product
      logic               mul_last;     // last step: the product replaces the running value
      logic               exp_shift;    // move to the next exponent bit
      logic               out_load;     // place the result in the output register
      modexp_out_sel_type out_sel;
   } modexp_cmd_type;

   typedef struct packed {
      logic exp_zero;
      logic mod_le_one;
      logic exp_msb;
      logic out_busy;
   } modexp_status_type;

endpackage

/* hdl/modexp_ctrl.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences base reduction, then one squaring and an optional multiply for
// every exponent bit from the top down, then hands the result out.
// ----------------------------------------------------------------------------
module modexp_ctrl
   import modexp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  modexp_status_type status,
   output modexp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REDUCE,
      ST_SQ_LOAD,
      ST_SQUARE,
      ST_MUL_LOAD,
      ST_MULTIPLY,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_WIDTH-1:0] step_cnt_ff, step_cnt_in;
   logic [CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   modexp_out_sel_type out_sel_ff, out_sel_in;
   logic               req_ready_ff, req_ready_in;

   logic step_last;
   logic bit_last;

   assign step_last  = (step_cnt_ff == CNT_LAST);
   assign bit_last   = (bit_cnt_ff == CNT_LAST);
   assign req_tready = req_ready_ff;

   always_comb begin
      state_in     = state_ff;
      step_cnt_in  = step_cnt_ff;
      bit_cnt_in   = bit_cnt_ff;
      out_sel_in   = out_sel_ff;
      req_ready_in = req_ready_ff;
      cmd          = '0;
      cmd.out_sel  = out_sel_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready_in = 1'b1;
            if (req_tvalid && req_ready_ff) begin
               cmd.load     = 1'b1;
               req_ready_in = 1'b0;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            step_cnt_in = '0;
            bit_cnt_in  = '0;
            if (status.exp_zero) begin
               out_sel_in = OUT_ONE;
               state_in   = ST_DONE;
            end else if (status.mod_le_one) begin
               out_sel_in = OUT_ZERO;
               state_in   = ST_DONE;
            end else begin
               out_sel_in = OUT_ACC;
               state_in   = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.reduce_step = 1'b1;
            step_cnt_in     = step_cnt_ff + 1'b1;
            if (step_last) begin
               state_in = ST_SQ_LOAD;
            end
         end
         ST_SQ_LOAD: begin
            cmd.mul_start = 1'b1;
            step_cnt_in   = '0;
            state_in      = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.mul_step = 1'b1;
            step_cnt_in  = step_cnt_ff + 1'b1;
            if (step_last) begin
               cmd.mul_last = 1'b1;
               if (status.exp_msb) begin
                  state_in = ST_MUL_LOAD;
               end else begin
                  cmd.exp_shift = 1'b1;
                  bit_cnt_in    = bit_cnt_ff + 1'b1;
                  state_in      = bit_last ? ST_DONE : ST_SQ_LOAD;
               end
            end
         end
         ST_MUL_LOAD: begin
            cmd.mul_start    = 1'b1;
            cmd.mul_sel_base = 1'b1;
            step_cnt_in      = '0;
            state_in         = ST_MULTIPLY;
         end
         ST_MULTIPLY: begin
            cmd.mul_step     = 1'b1;
            cmd.mul_sel_base = 1'b1;
            step_cnt_in      = step_cnt_ff + 1'b1;
            if (step_last) begin
               cmd.mul_last  = 1'b1;
               cmd.exp_shift = 1'b1;
               bit_cnt_in    = bit_cnt_ff + 1'b1;
               state_in      = bit_last ? ST_DONE : ST_SQ_LOAD;
            end
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
         step_cnt_ff  <= '0;
         bit_cnt_ff   <= '0;
         out_sel_ff   <= OUT_ACC;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         step_cnt_ff  <= step_cnt_in;
         bit_cnt_ff   <= bit_cnt_in;
         out_sel_ff   <= out_sel_in;
      end
   end

endmodule

/* hdl/modexp_dpath.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Holds the modulus, the operands, the running value and the shift-add
// modular multiplier, and drives the output register.
// ----------------------------------------------------------------------------
module modexp_dpath
   import modexp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [DATA_WIDTH-1:0] csr_wdata,
   input  logic [DATA_WIDTH-1:0] in_base,
   input  logic [DATA_WIDTH-1:0] in_power,
   input  modexp_cmd_type        cmd,
   output modexp_status_type     status,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [DATA_WIDTH-1:0] out_residue
);

   logic [DATA_WIDTH-1:0] modulus_ff;
   logic [DATA_WIDTH-1:0] base_ff;     // raw base, shifted out MSB first during reduction
   logic [DATA_WIDTH-1:0] exp_ff;      // exponent, current bit at the top
   logic [DATA_WIDTH-1:0] red_ff;      // reduced base once reduction is over
   logic [DATA_WIDTH-1:0] acc_ff;      // running value of the exponentiation
   logic [DATA_WIDTH-1:0] prod_ff;     // partial modular product
   logic [DATA_WIDTH-1:0] mul_y_ff;    // multiplier bits, MSB first
   logic [DATA_WIDTH-1:0] out_data_ff;
   logic                  out_valid_ff;

   logic [DATA_WIDTH:0]   red_shift;
   logic [DATA_WIDTH:0]   red_diff;
   logic [DATA_WIDTH-1:0] red_in;

   logic [DATA_WIDTH-1:0] mul_x;
   logic [DATA_WIDTH+1:0] mul_sum;
   logic [DATA_WIDTH+1:0] mul_m1;
   logic [DATA_WIDTH+1:0] mul_m2;
   logic [DATA_WIDTH-1:0] prod_in;
   logic [DATA_WIDTH-1:0] out_data_in;

   // Remainder by long division: shift in one base bit, subtract once.
   assign red_shift = {red_ff, base_ff[DATA_WIDTH-1]};
   assign red_diff  = red_shift - {1'b0, modulus_ff};
   assign red_in    = (red_shift >= {1'b0, modulus_ff}) ? red_diff[DATA_WIDTH-1:0]
                                                        : red_shift[DATA_WIDTH-1:0];

   // Partial product and multiplicand stay below the modulus, so twice the one plus
   // the other is below three moduli and one of three candidates is the reduced value.
   assign mul_x   = cmd.mul_sel_base ? red_ff : acc_ff;
   assign mul_sum = {1'b0, prod_ff, 1'b0}
                  + (mul_y_ff[DATA_WIDTH-1] ? {2'b00, mul_x} : '0);
   assign mul_m1  = {2'b00, modulus_ff};
   assign mul_m2  = {1'b0, modulus_ff, 1'b0};

   always_comb begin
      if (mul_sum >= mul_m2) begin
         prod_in = DATA_WIDTH'(mul_sum - mul_m2);
      end else if (mul_sum >= mul_m1) begin
         prod_in = DATA_WIDTH'(mul_sum - mul_m1);
      end else begin
         prod_in = mul_sum[DATA_WIDTH-1:0];
      end
   end

   always_comb begin
      case (cmd.out_sel)
         OUT_ACC:  out_data_in = acc_ff;
         OUT_ONE:  out_data_in = VALUE_ONE;
         OUT_ZERO: out_data_in = '0;
         default:  out_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= MODULUS_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            modulus_ff <= csr_wdata;
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff <= in_base;
         exp_ff  <= in_power;
         red_ff  <= '0;
         acc_ff  <= VALUE_ONE;
      end else begin
         if (cmd.reduce_step) begin
            base_ff <= {base_ff[DATA_WIDTH-2:0], 1'b0};
            red_ff  <= red_in;
         end
         if (cmd.exp_shift) begin
            exp_ff <= {exp_ff[DATA_WIDTH-2:0], 1'b0};
         end
         if (cmd.mul_last) begin
            acc_ff <= prod_in;
         end
      end

      if (cmd.mul_start) begin
         prod_ff  <= '0;
         mul_y_ff <= acc_ff;
      end else if (cmd.mul_step) begin
         prod_ff  <= prod_in;
         mul_y_ff <= {mul_y_ff[DATA_WIDTH-2:0], 1'b0};
      end

      if (cmd.out_load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign status.exp_zero   = (exp_ff == '0);
   assign status.mod_le_one = (modulus_ff <= VALUE_ONE);
   assign status.exp_msb    = exp_ff[DATA_WIDTH-1];
   assign status.out_busy   = out_valid_ff && !out_ready;

   assign out_valid   = out_valid_ff;
   assign out_residue = out_data_ff;

endmodule

/* hdl/modular_exponentiation.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation
// Computes base_value to the power, modulo the configured modulus, by
// square-and-multiply with a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries base_value and power; the response channel
//   returns one residue per request. The user is to write the modulus through
//   csr_we and csr_wdata only while the block is idle; the block itself does
//   not enforce this. The modulus resets to 1000000007. One item is in work at
//   a time. The base is first reduced, one bit at a time; then every exponent
//   bit, from the top down, gets a squaring and, when the bit is one, a
//   multiply. The bit-serial multiplier takes one multiplier bit per cycle.
//   A zero exponent or a modulus of zero or one returns without these steps.
//   The result sits in an output register; a new request is taken while it
//   waits, and a finished item waits for it to drain if the receiver stalls.
//   Reset is synchronous: it drops req_tready and rsp_tvalid and restores
//   the modulus; req_tready rises in the cycle after reset is released.
// ----------------------------------------------------------------------------
module modular_exponentiation
   import modexp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [DATA_WIDTH-1:0]      csr_wdata,      // modulus
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,      // base_value, power, zero fill
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata       // residue, zero fill
);

   modexp_cmd_type        cmd;
   modexp_status_type     status;
   logic [DATA_WIDTH-1:0] residue;

   modexp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   modexp_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .in_base     (req_tdata[DATA_WIDTH-1:0]),
      .in_power    (req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
      .cmd         (cmd),
      .status      (status),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_residue (residue)
   );

   assign rsp_tdata = RSP_TDATA_WIDTH'(residue);

endmodule

/* hdl/modexp_checker.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Port-level checks of the modular exponentiation block, bound to the top.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_macros.svh"

module modexp_checker
   import modexp_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   logic req_fire;
   logic rsp_stall;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // A stalled result keeps its value.
   `MODEXP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // Only one item is in work: the block closes its input right after taking one.
   `MODEXP_ASSERT_NEXT(a_one_in_flight, clock, reset, req_fire, !req_tready)

   // No result can be ready in the cycle after an item arrives.
   `MODEXP_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_fire, !$rose(rsp_tvalid))

   // The output register is empty and the input closed when reset is released.
   `MODEXP_ASSERT_SAME(a_rsp_after_reset, clock, reset, $past(reset), !rsp_tvalid && !req_tready)

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (.*);

/* tb/modular_exponentiation_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives base and exponent items through the request stream and checks every
// residue against a fixed table value or a predictor built on exact wide
// products. Directed items come first, then random phases under random moduli.
// ----------------------------------------------------------------------------
module modular_exponentiation_test
   import modexp_pkg::*;
;

   typedef logic [DATA_WIDTH-1:0]   value_type;
   typedef logic [2*DATA_WIDTH-1:0] wide_type;

   typedef struct {
      logic      set_modulus;
      value_type modulus;
      value_type base_value;
      value_type power;
      logic      fixed;
      value_type fixed_residue;
   } stim_row_type;

   localparam int        CLOCK_HALF   = 5;
   localparam int        RESET_CYCLES = 6;
   localparam int        RANDOM_ITEMS = 75;
   localparam int        LONG_HOLD    = 30000;
   localparam int        TAIL_CYCLES  = 40;
   localparam longint    CYCLE_LIMIT  = 5000000;
   localparam value_type VALUE_MAX    = '1;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic [DATA_WIDTH-1:0]      csr_wdata = '0;       // modulus
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;       // base_value, power, zero fill
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;            // residue, zero fill

   value_type    expected_residues[$];
   stim_row_type directed_rows[$];
   value_type    current_modulus = MODULUS_RESET;
   logic         idle_enable = 1'b1;
   logic         long_hold_request = 1'b0;
   int           error_count = 0;
   int           items_sent = 0;
   int           modulus_writes = 0;
   int           results_checked = 0;
   longint       cycle_count = 0;

   modular_exponentiation uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding.",
                  cycle_count, expected_residues.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Square-and-multiply over all exponent bits, each product formed at full
   // width before it is reduced.
   function automatic value_type modpow_residue(input value_type b, input value_type p,
                                                input value_type m);
      wide_type  prod;
      value_type acc;
      value_type reduced_base;
      int        i;
      if (p == '0) return VALUE_ONE;
      if (m <= VALUE_ONE) return '0;
      reduced_base = b % m;
      acc = VALUE_ONE;
      for (i = DATA_WIDTH - 1; i >= 0; i--) begin
         prod = wide_type'(acc) * wide_type'(acc);
         acc = value_type'(prod % wide_type'(m));
         if (p[i]) begin
            prod = wide_type'(acc) * wide_type'(reduced_base);
            acc = value_type'(prod % wide_type'(m));
         end
      end
      return acc;
   endfunction

   function automatic value_type random_value();
      return value_type'({$urandom, $urandom});
   endfunction

   task automatic add_row(input logic set_mod, input value_type m, input value_type b,
                          input value_type p, input logic fixed, input value_type r);
      stim_row_type row;
      row.set_modulus   = set_mod;
      row.modulus       = m;
      row.base_value    = b;
      row.power         = p;
      row.fixed         = fixed;
      row.fixed_residue = r;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic push_request(input value_type b, input value_type p,
                               input value_type residue);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_WIDTH'({p, b});
      do @(posedge clock); while (!req_tready);
      expected_residues.insert(expected_residues.size(), residue);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (expected_residues.size() != 0);
   endtask

   task automatic write_modulus(input value_type m);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(negedge clock);
      csr_we <= 1'b0;
      current_modulus = m;
      modulus_writes++;
   endtask

   // Receiver: one ready decision per falling edge, stalls counted here.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold_request) begin
            long_hold_request = 1'b0;
            stall_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_residues.size() == 0) begin
            $error("result item with no request outstanding: residue %0d",
                   rsp_tdata[DATA_WIDTH-1:0]);
            error_count++;
         end else begin
            if (rsp_tdata[DATA_WIDTH-1:0] !== expected_residues[0]) begin
               $error("residue mismatch: expected %0d, actual %0d",
                      expected_residues[0], rsp_tdata[DATA_WIDTH-1:0]);
               error_count++;
            end
            void'(expected_residues.pop_front());
            results_checked++;
         end
      end
   end

   initial begin
      int           i;
      int           random_count;
      int           phase;
      int           n;
      logic         last_phase;
      value_type    m;
      value_type    b;
      value_type    p;
      value_type    r;
      stim_row_type row;

      // Directed table. The first rows run under the modulus left by reset.
      add_row(0, '0, 63'd2, 63'd10, 1, 63'd1024);
      add_row(0, '0, '0, '0, 1, VALUE_ONE);
      add_row(0, '0, VALUE_MAX, '0, 1, VALUE_ONE);
      add_row(0, '0, '0, 63'd5, 1, '0);
      add_row(0, '0, VALUE_ONE, VALUE_MAX, 1, VALUE_ONE);
      add_row(0, '0, VALUE_MAX, VALUE_MAX, 0, '0);
      add_row(0, '0, 63'd1000000007, 63'd3, 1, '0);
      add_row(0, '0, 63'd1000000008, VALUE_MAX, 1, VALUE_ONE);
      // A modulus of one still returns one for a zero exponent.
      add_row(1, VALUE_ONE, 63'd5, '0, 1, VALUE_ONE);
      add_row(0, '0, 63'd5, 63'd7, 1, '0);
      add_row(0, '0, VALUE_MAX, VALUE_MAX, 1, '0);
      add_row(1, VALUE_MAX, VALUE_MAX, VALUE_ONE, 1, '0);
      add_row(0, '0, VALUE_MAX - 1, 63'd2, 1, VALUE_ONE);
      add_row(0, '0, VALUE_MAX - 1, 63'd3, 1, VALUE_MAX - 1);
      add_row(0, '0, 63'd2, 63'd62, 1, 63'h4000_0000_0000_0000);
      add_row(0, '0, 63'd2, 63'd63, 1, VALUE_ONE);
      add_row(0, '0, 63'h2AAA_5555_F0F0_0F0F, VALUE_MAX, 0, '0);
      add_row(1, 63'd2, 63'd3, VALUE_MAX, 1, VALUE_ONE);
      add_row(0, '0, 63'd4, VALUE_ONE, 1, '0);
      add_row(1, 63'h4000_0000_0000_0001, VALUE_MAX, VALUE_MAX, 0, '0);
      add_row(0, '0, '0, '0, 1, VALUE_ONE);
      // Fermat: three to the modulus minus one is one for this prime.
      add_row(1, 63'd1000000007, 63'd3, 63'd1000000006, 1, VALUE_ONE);

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.set_modulus) begin
            drain_results();
            write_modulus(row.modulus);
         end
         r = row.fixed ? row.fixed_residue
                       : modpow_residue(row.base_value, row.power, current_modulus);
         push_request(row.base_value, row.power, r);
      end

      random_count = 0;
      phase = 0;
      while (random_count < RANDOM_ITEMS) begin
         n = $urandom_range(6, 16);
         last_phase = (random_count + n >= RANDOM_ITEMS);
         drain_results();
         idle_enable = last_phase ? 1'b0 : ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 6))
            0:       m = VALUE_ONE;
            1:       m = 63'd2;
            2:       m = VALUE_MAX;
            3:       m = value_type'($urandom_range(3, 1000));
            4:       m = value_type'($urandom);
            default: m = random_value();
         endcase
         if (m == '0) m = VALUE_MAX;
         write_modulus(m);
         // One phase lets the block fill up behind a stalled receiver.
         if (phase == 1) long_hold_request = 1'b1;
         for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 7))
               0:       b = '0;
               1:       b = VALUE_MAX;
               2:       b = value_type'($urandom_range(0, 15));
               default: b = random_value();
            endcase
            case ($urandom_range(0, 9))
               0:       p = '0;
               1:       p = VALUE_MAX;
               2:       p = value_type'($urandom_range(1, 64));
               3:       p = VALUE_ONE << $urandom_range(0, DATA_WIDTH - 1);
               default: p = random_value();
            endcase
            push_request(b, p, modpow_residue(b, p, current_modulus));
         end
         random_count += n;
         phase++;
      end

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_residues.size() != 0) begin
         $error("%0d expected residues never arrived", expected_residues.size());
         error_count++;
      end

      $display("Sent %0d items (%0d from the table) under %0d modulus writes; %0d checked.",
               items_sent, directed_rows.size(), modulus_writes, results_checked);
      $display("Receiver held off once for %0d cycles; gaps on both sides in most phases.",
               LONG_HOLD);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
